// File: rtl/skf_pkg.sv
// shared constants, types and codes for the scalar kalman smoother
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  // sample width and fixed point format
  localparam int SAMPLE_BITS = 24;
  localparam int Q_SHIFT     = 28;
  localparam int QUO_W       = Q_SHIFT + 1;      // gain spans 0 .. 2^28
  localparam int VAR_W       = 32;
  localparam int DEN_W       = VAR_W + 1;
  localparam int CNT_W       = $clog2(QUO_W);

  // register file
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 2'd1;

  // reset values
  localparam logic [VAR_W-1:0] PNOISE_RESET = 32'd18790482;
  localparam logic [VAR_W-1:0] MNOISE_RESET = 32'd1342177280;
  localparam logic [VAR_W-1:0] VAR_RESET    = 32'd268435456;
  localparam logic [QUO_W-1:0] Q_ONE        = QUO_W'(1) << Q_SHIFT;

  // estimate range and reset estimate clamped into it
  localparam longint EST_MAX_L   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint EST_RESET_L = (4400 > EST_MAX_L) ? EST_MAX_L : 4400;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t EST_MAX   = sample_t'(EST_MAX_L);
  localparam sample_t EST_MIN   = sample_t'(-EST_MAX_L - 1);
  localparam sample_t EST_RESET = sample_t'(EST_RESET_L);

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/skf_div.sv
// restoring divider for the q.28 gain, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module skf_div
  import skf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAR_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic      [QUO_W-1:0] quotient,
  output div_stat_t             stat
);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             first;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // first step compares the dividend itself, later steps shift in a zero
  always_comb begin
    trial = first ? {1'b0, rem} : {rem, 1'b0};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat  <= '0;
      cnt   <= '0;
      first <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(QUO_W - 1);
        first     <= 1'b1;
      end else if (stat.busy) begin
        first <= 1'b0;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      dsr      <= divisor;
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quotient <= {quotient[QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: rtl/scalar_kalman_smoother.sv
// top level of the scalar kalman smoother: sequencer, shared multiplier, state
//
//   channel   direction  handshake                     payload
//   sample    in         sample_valid / sample_ready   sample
//   estimate  out        estimate_valid / estimate_ready estimate
//   cfg       in         cfg_valid / cfg_ready         cfg_index, cfg_data
//
// an item passes from acceptance to its result through a setup state, the divide
// state (the bit-serial gain divider forms 29 quotient bits and the gain is then
// taken), two passes through the shared multiplier, an accumulate state and an
// output state; the next item is taken at the earliest in the cycle after the
// result, so items do not overlap.
// sample_ready is high only while the sequencer idles; cfg_ready is always high.
// rst is synchronous and restores the estimate, variance and both noise registers.
// a result waiting on estimate_ready holds the next item in its output cycle.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_smoother
  import skf_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 sample_valid,
  output logic                      sample_ready,
  input  wire sample_t              sample,
  output logic                      estimate_valid,
  input  wire logic                 estimate_ready,
  output sample_t                   estimate,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VAR_W-1:0]     cfg_data
);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int OPD_W  = DEN_W + 1;
  localparam int PROD_W = 2 * OPD_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int T_W    = ACC_W - Q_SHIFT;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_MULV, S_MULE, S_SUM, S_DONE
  } state_t;

  state_t                     state;
  sample_t                    est_value;
  logic        [VAR_W-1:0]    err_variance;
  logic        [VAR_W-1:0]    process_noise;
  logic        [VAR_W-1:0]    measure_noise;
  sample_t                    s_reg;
  logic        [VAR_W-1:0]    pred;
  logic                       den_zero;
  sample_t                    ref_val;
  logic signed [DIFF_W-1:0]   diff_xr;
  logic signed [DIFF_W-1:0]   diff_sx;
  logic        [QUO_W-1:0]    gain;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic        [VAR_W:0]      pred_sum;
  logic        [VAR_W-1:0]    pred_c;
  logic        [DEN_W-1:0]    den_c;
  logic signed [DIFF_W-1:0]   mid_sum;
  logic signed [DIFF_W-1:0]   ref_c;
  logic signed [OPD_W-1:0]    mul_a;
  logic signed [OPD_W-1:0]    mul_b;
  logic signed [ACC_W-1:0]    acc_adj;
  logic signed [T_W-1:0]      t_val;
  logic signed [T_W:0]        new_sum;
  sample_t                    new_est;
  logic                       div_start;
  logic        [QUO_W-1:0]    quotient;
  div_stat_t                  div_stat;

  assign sample_ready = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign div_start    = (state == S_PREP);

  // predicted variance, denominator and midpoint reference
  always_comb begin
    pred_sum = {1'b0, err_variance} + {1'b0, process_noise};
    pred_c   = pred_sum[VAR_W] ? '1 : pred_sum[VAR_W-1:0];
    den_c    = {1'b0, pred_c} + {1'b0, measure_noise};
    mid_sum  = DIFF_W'(s_reg) + DIFF_W'(est_value);
    ref_c    = $signed(mid_sum + DIFF_W'(mid_sum[DIFF_W-1])) >>> 1;
  end

  skf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (pred_c),
    .divisor  (den_c),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // shared multiplier operands: variance update, then gain times innovation
  always_comb begin
    if (state == S_MULV) begin
      mul_a = OPD_W'(Q_ONE - gain);
      mul_b = OPD_W'(pred);
    end else begin
      mul_a = OPD_W'(gain);
      mul_b = OPD_W'(diff_sx);
    end
  end

  // truncate toward zero, add the reference and saturate
  always_comb begin
    acc_adj = acc + (acc[ACC_W-1] ? ACC_W'((64'd1 << Q_SHIFT) - 1) : '0);
    t_val   = acc_adj[ACC_W-1:Q_SHIFT];
    new_sum = (T_W + 1)'(ref_val) + (T_W + 1)'(t_val);
    if (new_sum > (T_W + 1)'(EST_MAX)) begin
      new_est = EST_MAX;
    end else if (new_sum < (T_W + 1)'(EST_MIN)) begin
      new_est = EST_MIN;
    end else begin
      new_est = new_sum[SAMPLE_BITS-1:0];
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      est_value      <= EST_RESET;
      err_variance   <= VAR_RESET;
      process_noise  <= PNOISE_RESET;
      measure_noise  <= MNOISE_RESET;
      estimate_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROCESS_NOISE: process_noise <= cfg_data;
          REG_MEASURE_NOISE: measure_noise <= cfg_data;
          default: ;
        endcase
      end
      if (estimate_valid && estimate_ready) begin
        estimate_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            s_reg <= sample;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          pred     <= pred_c;
          den_zero <= (den_c == '0);
          ref_val  <= ref_c[SAMPLE_BITS-1:0];
          diff_xr  <= DIFF_W'(est_value) - ref_c;
          diff_sx  <= DIFF_W'(s_reg) - DIFF_W'(est_value);
          state    <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            gain  <= den_zero ? '0 : quotient;
            state <= S_MULV;
          end
        end
        S_MULV: begin
          prod  <= mul_a * mul_b;
          state <= S_MULE;
        end
        S_MULE: begin
          err_variance <= prod[Q_SHIFT+VAR_W-1:Q_SHIFT];
          prod         <= mul_a * mul_b;
          state        <= S_SUM;
        end
        S_SUM: begin
          acc   <= (ACC_W'(diff_xr) <<< Q_SHIFT) + ACC_W'(prod);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!estimate_valid || estimate_ready) begin
            est_value      <= new_est;
            estimate       <= new_est;
            estimate_valid <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // gain from the divider never exceeds one
  a_gain_le_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULV) |-> (gain <= Q_ONE))
    else $error("gain above one");

  // variance update never exceeds the predicted variance
  a_var_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_MULE) |-> (prod[PROD_W-1:Q_SHIFT] <= (PROD_W - Q_SHIFT)'(pred)))
    else $error("variance grew");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_DIV))
    else $error("divider done outside divide state");

  // an accepted item starts a setup cycle and closes the input
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> (state == S_PREP) && !sample_ready)
    else $error("item accepted but sequencer did not start");

endmodule

`default_nettype wire
